[rtl/aer_pkg.sv]
// Package for the AER error status register set.
// Holds the item and result beat types, configuration type, command codes and
// register offsets. No dependencies.
package aer_pkg;

  // Command codes of an input beat.
  localparam logic [1:0] CMD_INJECT = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_WRITE  = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  // Injection result codes.
  localparam logic [1:0] INJ_OK          = 2'd0;
  localparam logic [1:0] INJ_COR_MASKED  = 2'd1;
  localparam logic [1:0] INJ_UNC_MASKED  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_UNCOR_SEVERITY = 2'd0;
  localparam logic [1:0] CFG_COR_MASK       = 2'd1;
  localparam logic [1:0] CFG_UNCOR_MASK     = 2'd2;
  localparam logic [1:0] CFG_MASK_OVERRIDE  = 2'd3;

  // Byte offsets within the AER capability.
  localparam logic [7:0] OFS_UNCOR_STATUS = 8'h04;
  localparam logic [7:0] OFS_COR_STATUS   = 8'h10;
  localparam logic [7:0] OFS_HEADER_LOG0  = 8'h1C;
  localparam logic [7:0] OFS_HEADER_LOG1  = 8'h20;
  localparam logic [7:0] OFS_HEADER_LOG2  = 8'h24;
  localparam logic [7:0] OFS_HEADER_LOG3  = 8'h28;
  localparam logic [7:0] OFS_ROOT_STATUS  = 8'h30;
  localparam logic [7:0] OFS_SOURCE_ID    = 8'h34;

  // Root error status bit positions.
  localparam int RS_COR         = 0;
  localparam int RS_MULTI_COR   = 1;
  localparam int RS_UNCOR       = 2;
  localparam int RS_MULTI_UNCOR = 3;
  localparam int RS_FIRST_FATAL = 4;
  localparam int RS_NONFATAL    = 5;
  localparam int RS_FATAL       = 6;

  localparam logic [31:0] SRC_HIGH_KEEP = 32'hffff0000;
  localparam logic [31:0] SRC_LOW_KEEP  = 32'h0000ffff;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  reg_offset;
    logic [31:0] write_data;
    logic [31:0] cor_bits;
    logic [31:0] uncor_bits;
    logic [7:0]  requester_bus;
    logic [7:0]  requester_devfn;
    logic [31:0] header_word0;
    logic [31:0] header_word1;
    logic [31:0] header_word2;
    logic [31:0] header_word3;
  } aer_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        hit;
    logic [1:0]  inject_result;
  } aer_rsp_t;

  typedef struct packed {
    logic [31:0] uncor_severity;
    logic [31:0] corr_err_mask;
    logic [31:0] unc_err_mask;
    logic        mask_override;
  } aer_cfg_t;

endpackage

[rtl/aer_cfg.sv]
// Configuration registers of the AER register set: severity, masks, override.
// Depends on aer_pkg.
module aer_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [31:0]         wr_data,
  output aer_pkg::aer_cfg_t   cfg
);

  aer_pkg::aer_cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (wr_en) begin
      case (wr_index)
        aer_pkg::CFG_UNCOR_SEVERITY: cfg_next.uncor_severity = wr_data;
        aer_pkg::CFG_COR_MASK:       cfg_next.corr_err_mask = wr_data;
        aer_pkg::CFG_UNCOR_MASK:     cfg_next.unc_err_mask = wr_data;
        aer_pkg::CFG_MASK_OVERRIDE:  cfg_next.mask_override = wr_data[0];
        default:                     cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

[rtl/aer_core.sv]
// Error status state and command execution of the AER register set.
// Computes one result per executed beat and updates the state. Depends on aer_pkg.
module aer_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  aer_pkg::aer_req_t   item,
  input  aer_pkg::aer_cfg_t   cfg,
  output aer_pkg::aer_rsp_t   result
);

  logic [31:0] unc_sts, unc_sts_next;
  logic [31:0] corr_sts, corr_sts_next;
  logic [31:0] header_log [4];
  logic [31:0] header_log_next [4];
  logic [31:0] root_sts, root_sts_next;
  logic [31:0] err_src_id, err_src_id_next;

  logic [15:0] src;
  logic        cor_any, unc_any, cor_masked, unc_masked;
  logic        dec_hit;
  logic [31:0] dec_value;
  logic [31:0] rs;

  assign src     = {item.requester_bus, item.requester_devfn};
  assign cor_any = |item.cor_bits;
  assign unc_any = |item.uncor_bits;
  assign cor_masked = !cfg.mask_override && cor_any &&
                      ((item.cor_bits & ~cfg.corr_err_mask) == '0);
  assign unc_masked = !cfg.mask_override && unc_any &&
                      ((item.uncor_bits & ~cfg.unc_err_mask) == '0);

  // Offset decode for reads.
  always_comb begin
    dec_hit   = 1'b1;
    dec_value = '0;
    case (item.reg_offset)
      aer_pkg::OFS_UNCOR_STATUS: dec_value = unc_sts;
      aer_pkg::OFS_COR_STATUS:   dec_value = corr_sts;
      aer_pkg::OFS_HEADER_LOG0:  dec_value = header_log[0];
      aer_pkg::OFS_HEADER_LOG1:  dec_value = header_log[1];
      aer_pkg::OFS_HEADER_LOG2:  dec_value = header_log[2];
      aer_pkg::OFS_HEADER_LOG3:  dec_value = header_log[3];
      aer_pkg::OFS_ROOT_STATUS:  dec_value = root_sts;
      aer_pkg::OFS_SOURCE_ID:    dec_value = err_src_id;
      default: dec_hit = 1'b0;
    endcase
  end

  // Root status update of an unmasked injection.
  always_comb begin
    rs = root_sts;
    if (cor_any) begin
      if (rs[aer_pkg::RS_COR]) begin
        rs[aer_pkg::RS_MULTI_COR] = 1'b1;
      end else begin
        rs[aer_pkg::RS_COR] = 1'b1;
      end
    end
    if (unc_any) begin
      if (rs[aer_pkg::RS_UNCOR]) begin
        rs[aer_pkg::RS_MULTI_UNCOR] = 1'b1;
      end
      if ((cfg.uncor_severity & item.uncor_bits) != '0) begin
        rs[aer_pkg::RS_FATAL] = 1'b1;
        if (!rs[aer_pkg::RS_UNCOR]) begin
          rs[aer_pkg::RS_FIRST_FATAL] = 1'b1;
        end
      end else begin
        rs[aer_pkg::RS_NONFATAL] = 1'b1;
      end
      rs[aer_pkg::RS_UNCOR] = 1'b1;
    end
  end

  always_comb begin
    unc_sts_next    = unc_sts;
    corr_sts_next   = corr_sts;
    header_log_next = header_log;
    root_sts_next   = root_sts;
    err_src_id_next = err_src_id;
    result          = '0;
    case (item.command)
      aer_pkg::CMD_INJECT: begin
        unc_sts_next       = unc_sts | item.uncor_bits;
        corr_sts_next      = corr_sts | item.cor_bits;
        header_log_next[0] = item.header_word0;
        header_log_next[1] = item.header_word1;
        header_log_next[2] = item.header_word2;
        header_log_next[3] = item.header_word3;
        if (cor_masked) begin
          result.inject_result = aer_pkg::INJ_COR_MASKED;
        end else if (unc_masked) begin
          result.inject_result = aer_pkg::INJ_UNC_MASKED;
        end else begin
          root_sts_next = rs;
          if (cor_any && unc_any) begin
            err_src_id_next = {src, src};
          end else if (cor_any) begin
            err_src_id_next = (err_src_id & aer_pkg::SRC_HIGH_KEEP) | {16'h0, src};
          end else if (unc_any) begin
            err_src_id_next = (err_src_id & aer_pkg::SRC_LOW_KEEP) | {src, 16'h0};
          end
        end
      end
      aer_pkg::CMD_READ: begin
        result.hit = dec_hit;
        result.read_data = dec_value;
      end
      aer_pkg::CMD_WRITE: begin
        result.hit = dec_hit;
        case (item.reg_offset)
          aer_pkg::OFS_UNCOR_STATUS:
            unc_sts_next = unc_sts & ~item.write_data;
          aer_pkg::OFS_COR_STATUS:
            corr_sts_next = corr_sts & ~item.write_data;
          aer_pkg::OFS_HEADER_LOG0: header_log_next[0] = item.write_data;
          aer_pkg::OFS_HEADER_LOG1: header_log_next[1] = item.write_data;
          aer_pkg::OFS_HEADER_LOG2: header_log_next[2] = item.write_data;
          aer_pkg::OFS_HEADER_LOG3: header_log_next[3] = item.write_data;
          aer_pkg::OFS_ROOT_STATUS:
            root_sts_next = root_sts & ~item.write_data;
          aer_pkg::OFS_SOURCE_ID: err_src_id_next = item.write_data;
          default: err_src_id_next = err_src_id;
        endcase
      end
      default: result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unc_sts    <= '0;
      corr_sts   <= '0;
      header_log <= '{default: '0};
      root_sts   <= '0;
      err_src_id <= '0;
    end else if (fire) begin
      unc_sts    <= unc_sts_next;
      corr_sts   <= corr_sts_next;
      header_log <= header_log_next;
      root_sts   <= root_sts_next;
      err_src_id <= err_src_id_next;
    end
  end

  // A write to a status register can only clear bits.
  a_w1c_clears: assert property (@(posedge clk) disable iff (rst)
    fire && item.command == aer_pkg::CMD_WRITE &&
    item.reg_offset == aer_pkg::OFS_ROOT_STATUS
    |=> (root_sts & ~$past(root_sts)) == '0)
    else $error("root status write set a bit");

  // A masked injection leaves the root registers alone.
  a_masked_root: assert property (@(posedge clk) disable iff (rst)
    fire && item.command == aer_pkg::CMD_INJECT && (cor_masked || unc_masked)
    |=> $stable(root_sts) && $stable(err_src_id))
    else $error("masked injection changed root registers");

  // An unmasked uncorrectable injection always leaves the received bit set.
  a_unc_received: assert property (@(posedge clk) disable iff (rst)
    fire && item.command == aer_pkg::CMD_INJECT && unc_any &&
    !cor_masked && !unc_masked
    |=> root_sts[aer_pkg::RS_UNCOR])
    else $error("uncorrectable received bit not set");

endmodule

[rtl/pcie_aer_error_status_model_unit.sv]
// Top level of the AER error status register set.
// Instantiates aer_cfg and aer_core; uses aer_pkg.
//
// Usage:
//   Request channel (req_valid, req_stall, req): one beat is one command -
//   inject an error, read a register, or write a register. A beat is taken
//   at a rising edge with req_valid high and req_stall low.
//   Response channel (rsp_valid, rsp_stall, rsp): exactly one result beat per
//   request beat, in order, taken at an edge with rsp_valid high and
//   rsp_stall low.
//   Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): writes
//   severity, correctable mask, uncorrectable mask and mask override by index.
//   It is always ready; write it only while no request is in flight.
// Flow: a request beat lands in an input register. Once the response
// register can take its result, the beat executes against the error
// state and loads the response register, and its result stays on rsp
// until taken. The command logic between those two registers is a single
// pass, so one beat per cycle is sustained while rsp is not stalled.
// Stall: while the response register is full and stalled, the held request
// waits and req_stall rises only if the input register is also occupied.
// Reset (rst, synchronous): clears all error state, configuration and valids.
module pcie_aer_error_status_model_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  aer_pkg::aer_req_t   req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output aer_pkg::aer_rsp_t   rsp,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  aer_pkg::aer_cfg_t cfg;
  aer_pkg::aer_req_t held;
  aer_pkg::aer_rsp_t result;
  logic              held_valid;
  logic              advance;

  assign cfg_ready = 1'b1;

  // The held beat executes whenever the response register can take its result.
  assign advance   = held_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = held_valid && !advance;

  aer_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  aer_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (held),
    .cfg    (cfg),
    .result (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      held <= req;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

  // The request side is only held off when a beat is waiting behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> held_valid && rsp_valid && rsp_stall)
    else $error("request stalled without a blocked result");

  // Every executed beat shows up as a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("executed beat produced no result");

  // An injection status and a register hit never appear in the same result.
  a_result_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.inject_result != aer_pkg::INJ_OK
    |-> !rsp.hit && rsp.read_data == '0)
    else $error("injection result mixed with register access");

endmodule
